// File: rtl/swept_wavetable_synth_assert.svh
// ---------------------------------------------------------------------------
// swept_wavetable_synth assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef SWEPT_WAVETABLE_SYNTH_ASSERT_SVH
`define SWEPT_WAVETABLE_SYNTH_ASSERT_SVH

// same-cycle implication
`define SWS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sws port check failed");

// next-cycle implication
`define SWS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sws port check failed");

`endif

// File: rtl/sws_pkg.sv
// ---------------------------------------------------------------------------
// sws_pkg
// Types, constants and helpers of the swept wavetable synth.
// ---------------------------------------------------------------------------
package sws_pkg;

	localparam int TABLE_DEPTH      = 256;
	localparam int SAMPLES_PER_STEP = 8;
	localparam int TBL_AW           = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SC_W             = (SAMPLES_PER_STEP > 1) ? $clog2(SAMPLES_PER_STEP) : 1;
	localparam int OUT_DEPTH        = 4;
	localparam int OUT_AW           = $clog2(OUT_DEPTH);

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	localparam logic [2:0] CFG_DURATION   = 3'd0;
	localparam logic [2:0] CFG_OFFSET     = 3'd1;
	localparam logic [2:0] CFG_DELTA      = 3'd2;
	localparam logic [2:0] CFG_DELTA_STEP = 3'd3;
	localparam logic [2:0] CFG_WAVE_MASK  = 3'd4;
	localparam logic [2:0] CFG_LFO_STEP   = 3'd5;

	localparam logic [7:0] VOL_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] table_index;
		logic [7:0] table_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] dac_value;
		logic       active;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic       valid;
		logic       tick;
		logic       clear;
		logic       active;
		logic       fin;
		logic [7:0] vol;
	} s1_t;

	function automatic logic [TBL_AW-1:0] tbl_wrap(input logic [7:0] v);
		logic [8:0] r;
		r = {1'b0, v};
		for (int i = 0; i < 8; i++) begin
			if (r >= 9'(TABLE_DEPTH)) begin
				r = r - 9'(TABLE_DEPTH);
			end
		end
		return r[TBL_AW-1:0];
	endfunction

endpackage

// File: rtl/sws_ram.sv
// ---------------------------------------------------------------------------
// sws_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module sws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/sws_sweep.sv
// ---------------------------------------------------------------------------
// sws_sweep
// Configuration registers, phase accumulator and sweep state; issues the
// table write, the table read and the stage-one control of each item.
// ---------------------------------------------------------------------------
module sws_sweep (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [2:0]                 cfg_index,
	input  logic [15:0]                cfg_data,
	input  logic                       in_accept,
	input  sws_pkg::in_item_t          in_item,
	output logic                       ram_we,
	output logic [sws_pkg::TBL_AW-1:0] ram_waddr,
	output logic [7:0]                 ram_wdata,
	output logic                       ram_re,
	output logic [sws_pkg::TBL_AW-1:0] ram_raddr,
	output sws_pkg::s1_t               ctl_s1
);
	import sws_pkg::*;

	logic [15:0]     duration_q, offset_q, delta_q, delta_step_q;
	logic [7:0]      wave_mask_q, lfo_step_q;
	logic [15:0]     phase_q, phase_step_q, step_change_q, remaining_q;
	logic [7:0]      volume_q;
	logic [SC_W-1:0] sc_q;
	logic            playing_q;

	logic [SC_W:0]   sc_inc;
	logic            step_now;
	logic [15:0]     rem_n;
	logic            is_load, is_start, is_tick;

	assign is_load  = in_accept && (in_item.func == FUNC_LOAD);
	assign is_start = in_accept && (in_item.func == FUNC_START);
	assign is_tick  = in_accept && (in_item.func == FUNC_TICK);
	assign sc_inc   = {1'b0, sc_q} + (SC_W+1)'(1);
	assign step_now = (sc_inc == (SC_W+1)'(SAMPLES_PER_STEP));
	assign rem_n    = remaining_q - 16'd1;

	assign ram_we    = is_load && ({1'b0, in_item.table_index} < 9'(TABLE_DEPTH));
	assign ram_waddr = in_item.table_index[TBL_AW-1:0];
	assign ram_wdata = in_item.table_value;
	assign ram_re    = is_tick && playing_q;
	assign ram_raddr = tbl_wrap(phase_q[15:8] & wave_mask_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q   <= '0;
			offset_q     <= '0;
			delta_q      <= '0;
			delta_step_q <= '0;
			wave_mask_q  <= 8'hFF;
			lfo_step_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DURATION:   duration_q   <= cfg_data;
				CFG_OFFSET:     offset_q     <= cfg_data;
				CFG_DELTA:      delta_q      <= cfg_data;
				CFG_DELTA_STEP: delta_step_q <= cfg_data;
				CFG_WAVE_MASK:  wave_mask_q  <= cfg_data[7:0];
				CFG_LFO_STEP:   lfo_step_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			phase_step_q  <= '0;
			step_change_q <= '0;
			remaining_q   <= '0;
			volume_q      <= VOL_MAX;
			sc_q          <= '0;
			playing_q     <= 1'b0;
		end else if (is_start) begin
			phase_q       <= offset_q;
			phase_step_q  <= delta_q;
			step_change_q <= delta_step_q;
			remaining_q   <= duration_q;
			volume_q      <= VOL_MAX;
			sc_q          <= '0;
			playing_q     <= (duration_q != 16'd0);
		end else if (is_tick && playing_q) begin
			phase_q <= phase_q + phase_step_q;
			if (step_now) begin
				sc_q          <= '0;
				remaining_q   <= rem_n;
				phase_step_q  <= phase_step_q + step_change_q;
				step_change_q <= step_change_q + {{8{lfo_step_q[7]}}, lfo_step_q};
				if (rem_n <= 16'h00FF) begin
					volume_q <= rem_n[7:0];
				end
				if (rem_n == 16'd0) begin
					playing_q <= 1'b0;
				end
			end else begin
				sc_q <= sc_inc[SC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= is_tick || (is_start && (duration_q == 16'd0));
			ctl_s1.tick   <= is_tick;
			ctl_s1.clear  <= is_start;
			ctl_s1.active <= playing_q;
			ctl_s1.fin    <= playing_q && step_now && (rem_n == 16'd0);
			ctl_s1.vol    <= volume_q;
		end
	end

endmodule

// File: rtl/sws_out_buf.sv
// ---------------------------------------------------------------------------
// sws_out_buf
// DAC hold register and result queue toward the output channel.
// ---------------------------------------------------------------------------
module sws_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  sws_pkg::s1_t       ctl_s1,
	input  logic [7:0]         rdata,
	input  logic               out_stall,
	output logic               out_valid,
	output sws_pkg::out_item_t out_item,
	output logic               in_stall
);
	import sws_pkg::*;

	logic [7:0]      hold_q;
	logic [7:0]      hold_n;
	out_item_t       res;
	out_item_t       buf_q [OUT_DEPTH];
	logic [OUT_AW-1:0] wp_q, rp_q;
	logic [OUT_AW:0]   cnt_q;
	logic            push, pop;

	assign push = ctl_s1.valid && ctl_s1.tick;
	assign pop  = out_valid && !out_stall;

	always_comb begin
		hold_n = hold_q;
		if (ctl_s1.active && (rdata <= ctl_s1.vol)) begin
			hold_n = rdata;
		end
		res.dac_value = hold_n;
		res.active    = ctl_s1.active;
		res.last      = ctl_s1.fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
		end else if (ctl_s1.valid) begin
			if (ctl_s1.clear || (ctl_s1.tick && ctl_s1.fin)) begin
				hold_q <= '0;
			end else if (ctl_s1.tick) begin
				hold_q <= hold_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + OUT_AW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + OUT_AW'(1);
			end
			cnt_q <= cnt_q + (OUT_AW+1)'(push) - (OUT_AW+1)'(pop);
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_item  = buf_q[rp_q];
	assign in_stall  = ((OUT_AW+2)'(cnt_q) + (OUT_AW+2)'(push)) >= (OUT_AW+2)'(OUT_DEPTH);

endmodule

// File: rtl/swept_wavetable_synth.sv
// ---------------------------------------------------------------------------
// swept_wavetable_synth
// Wavetable oscillator with a swept phase increment and a decaying volume.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_item): load a table byte, start a
// sound, or tick one sample. Only a tick yields a result.
// Output channel (out_valid / out_stall / out_item): one item per tick with
// the DAC byte, the active flag and the last-sample flag.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// write while idle, values take effect at the next start.
// A tick's result passes the stage-one registers (table read and control)
// and then the result queue before it is offered on the output channel.
// Throughput: one item per cycle while in_stall is low; the table RAM has one
// read and one write port and the sweep state updates in the accept cycle.
// A four-entry result queue absorbs receiver stalls; in_stall rises when the
// queue plus the item in flight would fill it.
// Reset: sound idle, DAC 0, volume 255, mask 255, other registers 0. The wave
// table is not cleared and must be loaded before it is played.
// ---------------------------------------------------------------------------
module swept_wavetable_synth (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sws_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output sws_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import sws_pkg::*;

	logic              in_accept;
	logic              ram_we, ram_re;
	logic [TBL_AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;
	s1_t               ctl_s1;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && !in_stall;

	sws_sweep u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_accept (in_accept),
		.in_item   (in_item),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ctl_s1    (ctl_s1)
	);

	sws_ram #(
		.WIDTH (8),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sws_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.rdata     (ram_rdata),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item),
		.in_stall  (in_stall)
	);

endmodule

// File: rtl/sws_checker.sv
// ---------------------------------------------------------------------------
// sws_checker
// Port-level checks of the swept wavetable synth, bound to the top level.
// ---------------------------------------------------------------------------
`include "swept_wavetable_synth_assert.svh"

module sws_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input sws_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_stall,
	input sws_pkg::out_item_t out_item
);
	import sws_pkg::*;

	`SWS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
	`SWS_ASSERT_NOW(a_last_active, out_valid && out_item.last, out_item.active)
	`SWS_ASSERT_NOW(a_tick_result, in_valid && !in_stall && (in_item.func == FUNC_TICK), ##2 out_valid)
	`SWS_ASSERT_NOW(a_empty_ready, !out_valid, !in_stall)

endmodule

bind swept_wavetable_synth sws_checker u_sws_checker (.*);
